@@ design/asseg_pkg.sv @@
// Shared types, constants and the segment font for the ASCII to seven-segment stream encoder.
// Used by asseg_ctrl, asseg_dp and ascii_to_seven_segment_stream; depends on nothing else.
`timescale 1ns / 1ps

package asseg_pkg;

	localparam int DIGITS_DEF = 6;
	localparam int CNT_W = 6;

	localparam logic [7:0] SG_A = 8'h01;
	localparam logic [7:0] SG_B = 8'h02;
	localparam logic [7:0] SG_C = 8'h04;
	localparam logic [7:0] SG_D = 8'h08;
	localparam logic [7:0] SG_E = 8'h10;
	localparam logic [7:0] SG_F = 8'h20;
	localparam logic [7:0] SG_G = 8'h40;
	localparam logic [7:0] SG_DP = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	localparam logic [7:0] DOT_CODE = 8'h2E;
	localparam logic [7:0] SPACE_CODE = 8'd32;
	localparam logic [7:0] MINUS_CODE = 8'd45;
	localparam logic [7:0] COLON_CODE = 8'd58;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROC  = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the input request
		logic step;   // process a non-final request
		logic setup;  // prepare the byte sequence of a final request
		logic emit;   // emit the next byte of the final sequence
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic item_final;
		logic out_free;
		logic last_byte;
	} sts_t;

	function automatic logic [7:0] font(input logic [7:0] ch);
		logic [7:0] seg;
		case (ch)
			SPACE_CODE: seg = SEG_BLANK;
			MINUS_CODE: seg = SG_G;
			8'd48:      seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F;
			8'd49:      seg = SG_B | SG_C;
			8'd50:      seg = SG_A | SG_B | SG_G | SG_D | SG_E;
			8'd51:      seg = SG_A | SG_B | SG_C | SG_D | SG_G;
			8'd52:      seg = SG_F | SG_G | SG_B | SG_C;
			8'd53:      seg = SG_A | SG_F | SG_C | SG_D | SG_G;
			8'd54:      seg = SG_A | SG_F | SG_C | SG_D | SG_G | SG_E;
			8'd55:      seg = SG_A | SG_B | SG_C;
			8'd56:      seg = SG_A | SG_B | SG_C | SG_D | SG_E | SG_F | SG_G;
			8'd57:      seg = SG_A | SG_B | SG_C | SG_D | SG_F | SG_G;
			COLON_CODE: seg = SG_DP;
			8'd69:      seg = SG_A | SG_D | SG_E | SG_F | SG_G;
			8'd83:      seg = SG_A | SG_C | SG_D | SG_F | SG_G;
			8'd99:      seg = SG_D | SG_E | SG_G;
			8'd100:     seg = SG_B | SG_C | SG_D | SG_E | SG_G;
			8'd114:     seg = SG_E | SG_G;
			8'd117:     seg = SG_C | SG_D | SG_E;
			default:    seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

@@ design/asseg_ctrl.sv @@
// Controller state machine of the seven-segment stream encoder.
// Depends on asseg_pkg; drives the datapath asseg_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module asseg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  asseg_pkg::sts_t  sts,
	output asseg_pkg::cmd_t  cmd
);

	asseg_pkg::state_t state_q;
	asseg_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			asseg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = asseg_pkg::ST_PROC;
				end
			end
			asseg_pkg::ST_PROC: begin
				if (sts.item_final) begin
					cmd.setup = 1'b1;
					state_d = asseg_pkg::ST_FINAL;
				end else if (sts.out_free) begin
					cmd.step = 1'b1;
					state_d = asseg_pkg::ST_IDLE;
				end
			end
			asseg_pkg::ST_FINAL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_byte) begin
						state_d = asseg_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = asseg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asseg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/asseg_dp.sv @@
// Datapath of the seven-segment stream encoder: request register, held character,
// byte counter and output register. Depends on asseg_pkg; commanded by asseg_ctrl.
`timescale 1ns / 1ps

module asseg_dp #(
	parameter int DIGITS = asseg_pkg::DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       character,
	input  logic             no_character,
	input  logic             final_req,
	output logic [7:0]       segments,
	output logic             latch,
	output logic             out_valid,
	input  logic             out_ready,
	input  asseg_pkg::cmd_t  cmd,
	output asseg_pkg::sts_t  sts
);

	localparam logic [asseg_pkg::CNT_W-1:0] DIG_CNT = asseg_pkg::CNT_W'(DIGITS);

	logic [7:0] char_q;
	logic       none_q;
	logic       final_q;
	logic [7:0] held_char_q;
	logic       held_valid_q;
	logic [asseg_pkg::CNT_W-1:0] count_q;
	logic       flush_pend_q;
	logic       char_pend_q;
	logic [7:0] seg_q;
	logic       latch_q;
	logic       out_valid_q;

	logic       item_dot;
	logic       flush_emit;
	logic [7:0] flush_seg;
	logic [asseg_pkg::CNT_W-1:0] count_inc;
	logic       last_byte;
	logic [7:0] final_seg;
	logic       load_out;

	assign item_dot = !none_q && (char_q == asseg_pkg::DOT_CODE);
	// A held dot is dropped unless the next character is a dot as well.
	assign flush_emit = held_valid_q && (item_dot || held_char_q != asseg_pkg::DOT_CODE);
	assign flush_seg = asseg_pkg::font(held_char_q) | (item_dot ? asseg_pkg::SG_DP : 8'h00);
	assign count_inc = (count_q >= DIG_CNT) ? count_q : count_q + 1'b1;
	assign last_byte = !(flush_pend_q && char_pend_q) && (count_inc >= DIG_CNT);
	assign final_seg = flush_pend_q ? flush_seg :
		(char_pend_q ? asseg_pkg::font(char_q) : asseg_pkg::SEG_BLANK);
	assign load_out = cmd.emit || (cmd.step && !none_q && flush_emit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= character;
			none_q <= no_character;
			final_q <= final_req;
		end
		if (cmd.emit) begin
			seg_q <= final_seg;
			latch_q <= last_byte;
		end else if (load_out) begin
			seg_q <= flush_seg;
			latch_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q <= '0;
			held_valid_q <= 1'b0;
			count_q <= '0;
			flush_pend_q <= 1'b0;
			char_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.step && !none_q) begin
				if (flush_emit) begin
					count_q <= count_inc;
				end
				held_char_q <= char_q;
				held_valid_q <= 1'b1;
			end
			if (cmd.setup) begin
				flush_pend_q <= flush_emit;
				char_pend_q <= !none_q && (char_q != asseg_pkg::DOT_CODE);
				held_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				if (flush_pend_q) begin
					flush_pend_q <= 1'b0;
				end else begin
					char_pend_q <= 1'b0;
				end
				if (last_byte) begin
					count_q <= '0;
					held_char_q <= '0;
				end else begin
					count_q <= count_inc;
				end
			end
		end
	end

	assign segments = seg_q;
	assign latch = latch_q;
	assign out_valid = out_valid_q;
	assign sts.item_final = final_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last_byte = last_byte;

endmodule

@@ design/ascii_to_seven_segment_stream.sv @@
// ASCII to seven-segment stream encoder, top level. Depends on asseg_pkg, asseg_ctrl, asseg_dp.
// A non-final request is captured, then puts at most one byte into the free output register.
// A final request is captured and set up, then emits its bytes one by one (flush, character,
// padding up to DIGITS) through the single-byte output register; output stalls hold it.
// A non-final byte is valid after capture and step; the first final byte after setup and emit.
// Reset clears the held character, the byte counter and the output valid flag.
`timescale 1ns / 1ps

module ascii_to_seven_segment_stream #(
	parameter int DIGITS = asseg_pkg::DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       no_character,
	input  logic       final_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] segments,
	output logic       latch
);

	asseg_pkg::cmd_t cmd;
	asseg_pkg::sts_t sts;

	asseg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	asseg_dp #(
		.DIGITS (DIGITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.character    (character),
		.no_character (no_character),
		.final_req    (final_req),
		.segments     (segments),
		.latch        (latch),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	// Only one datapath command is issued per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.setup, cmd.emit}))
		else $error("more than one datapath command in a cycle");

	// A byte is never written over one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.step) |-> (!out_valid || out_ready))
		else $error("output byte overwritten");

	// A latched byte ends the string, so the block is ready for a new request next.
	a_latch_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.last_byte) |=> (in_ready && out_valid && latch))
		else $error("latch byte did not end the string");

endmodule
